@@ hdl/fds_pkg.sv @@
// ---------------------------------------------------------------------------
// fds_pkg: shared types and constants of the decimal string converter
// Character codes, powers of ten, field widths and the per-item flags
// that travel down the pipeline with each value.
// ---------------------------------------------------------------------------
package fds_pkg;

  // Field widths fixed by the stream format.
  localparam int VALUE_W = 32;
  localparam int CHAR_W  = 8;
  localparam int DEC_W   = 4;
  localparam int DIGIT_W = 4;

  // Defaults of the top-level parameters.
  localparam int DEF_MAX_DECIMALS = 8;
  localparam int DEF_FRAC_BITS    = 28;

  // Value of the decimals register after reset.
  localparam logic [DEC_W-1:0] RESET_DECIMALS = 4'd2;

  // ASCII codes of the emitted characters.
  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_POINT = 8'h2E;
  localparam logic [CHAR_W-1:0] CHAR_NONE  = 8'h00;

  // Powers of ten up to one past the largest decimals setting.
  localparam longint unsigned POW10 [10] = '{
    64'd1, 64'd10, 64'd100, 64'd1000, 64'd10000, 64'd100000,
    64'd1000000, 64'd10000000, 64'd100000000, 64'd1000000000
  };

  // Flags that travel with each value through the pipeline.
  typedef struct packed {
    logic             err;
    logic [DEC_W-1:0] dec;
  } fds_ctl_t;

  // Number of bits needed to hold the value x.
  function automatic int fds_nbits(longint unsigned x);
    int n;
    n = 1;
    for (int i = 0; i < 64; i++) begin
      if ((x >> i) != 64'd0) n = i + 1;
    end
    return n;
  endfunction

endpackage

@@ hdl/fds_front.sv @@
// ---------------------------------------------------------------------------
// fds_front: scaling and rounding stages
// Multiplies the value by ten to the number of decimals, adds one half,
// drops the fraction bits and flags range and rounding overflow.
// ---------------------------------------------------------------------------
module fds_front #(
  parameter int MAX_DECIMALS = fds_pkg::DEF_MAX_DECIMALS,
  parameter int FRAC_BITS    = fds_pkg::DEF_FRAC_BITS,
  parameter int RW           = 30
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [fds_pkg::VALUE_W-1:0] in_value,
  input  logic [fds_pkg::DEC_W-1:0]   dec_cfg,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [RW-1:0]               out_rem,
  output fds_pkg::fds_ctl_t           out_ctl
);
  import fds_pkg::*;

  localparam int SW   = fds_nbits(POW10[MAX_DECIMALS]);
  localparam int PRW  = VALUE_W + SW;
  localparam int SUMW = ((PRW > FRAC_BITS) ? PRW : FRAC_BITS) + 1;

  logic [DEC_W-1:0] dec_eff;
  logic [SW-1:0]    scale;
  logic             range_err;

  logic             a_valid;
  logic             a_ready;
  logic [PRW-1:0]   a_prod;
  fds_ctl_t         a_ctl;

  logic [SUMW-1:0]  sum;
  logic [SUMW-1:0]  shifted;
  logic [SUMW-1:0]  limit;
  logic             carry_err;

  // Settings above the supported count round to the maximum.
  assign dec_eff   = (dec_cfg > DEC_W'(MAX_DECIMALS)) ? DEC_W'(MAX_DECIMALS) : dec_cfg;
  assign scale     = SW'(POW10[dec_eff]);
  assign range_err = (in_value >> FRAC_BITS) > VALUE_W'(9);

  // Stage A handshake: a slot frees when stage B can take its contents.
  assign a_ready  = !out_valid || out_ready;
  assign in_ready = !a_valid || a_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (in_ready) begin
      a_valid <= in_valid;
    end
  end

  // Stage A: the multiply.
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      a_prod    <= PRW'(in_value) * PRW'(scale);
      a_ctl.err <= range_err;
      a_ctl.dec <= dec_eff;
    end
  end

  // Round half up and check the result against ten times the scale.
  assign sum       = SUMW'(a_prod) + (SUMW'(1) << (FRAC_BITS - 1));
  assign shifted   = sum >> FRAC_BITS;
  assign limit     = SUMW'(POW10[DEC_W'(a_ctl.dec + DEC_W'(1))]);
  assign carry_err = shifted >= limit;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (a_ready) begin
      out_valid <= a_valid;
    end
  end

  // Stage B: the rounded integer.
  always_ff @(posedge clk) begin
    if (a_ready && a_valid) begin
      out_rem     <= shifted[RW-1:0];
      out_ctl.err <= a_ctl.err || carry_err;
      out_ctl.dec <= a_ctl.dec;
    end
  end

endmodule

@@ hdl/fds_digit.sv @@
// ---------------------------------------------------------------------------
// fds_digit: one decimal digit extraction stage
// Finds the digit of the remainder at one power of ten by parallel
// compares against its nine multiples, then subtracts it out.
// ---------------------------------------------------------------------------
module fds_digit #(
  parameter int MAX_DECIMALS = fds_pkg::DEF_MAX_DECIMALS,
  parameter int RW           = 30,
  parameter int P            = 0
) (
  input  logic                                      clk,
  input  logic                                      rst,
  input  logic                                      in_valid,
  output logic                                      in_ready,
  input  logic [RW-1:0]                             in_rem,
  input  logic [MAX_DECIMALS:0][fds_pkg::DIGIT_W-1:0] in_digs,
  input  fds_pkg::fds_ctl_t                         in_ctl,
  output logic                                      out_valid,
  input  logic                                      out_ready,
  output logic [RW-1:0]                             out_rem,
  output logic [MAX_DECIMALS:0][fds_pkg::DIGIT_W-1:0] out_digs,
  output fds_pkg::fds_ctl_t                         out_ctl
);
  import fds_pkg::*;

  localparam longint unsigned STEP = POW10[P];

  logic [DIGIT_W-1:0]               digit;
  logic [RW-1:0]                    rem_next;
  logic [MAX_DECIMALS:0][DIGIT_W-1:0] digs_next;

  // Largest multiple of the step that fits in the remainder.
  always_comb begin
    digit = '0;
    for (int k = 1; k < 10; k++) begin
      if (64'(in_rem) >= STEP * 64'(k)) digit = DIGIT_W'(k);
    end
    rem_next     = in_rem - RW'(STEP * 64'(digit));
    digs_next    = in_digs;
    digs_next[P] = digit;
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_rem  <= rem_next;
      out_digs <= digs_next;
      out_ctl  <= in_ctl;
    end
  end

endmodule

@@ hdl/fds_serial.sv @@
// ---------------------------------------------------------------------------
// fds_serial: character serializer
// Holds one converted value, trims trailing zero digits and sends its
// characters one beat per ready cycle through a registered output stage.
// ---------------------------------------------------------------------------
module fds_serial #(
  parameter int MAX_DECIMALS = fds_pkg::DEF_MAX_DECIMALS
) (
  input  logic                                      clk,
  input  logic                                      rst,
  input  logic                                      in_valid,
  output logic                                      in_ready,
  input  logic [MAX_DECIMALS:0][fds_pkg::DIGIT_W-1:0] in_digs,
  input  fds_pkg::fds_ctl_t                         in_ctl,
  output logic                                      m_tvalid,
  input  logic                                      m_tready,
  output logic [fds_pkg::CHAR_W-1:0]                m_tdata,
  output logic                                      m_tlast,
  output logic                                      m_tuser
);
  import fds_pkg::*;

  localparam int PW = (MAX_DECIMALS > 0) ? $clog2(MAX_DECIMALS + 1) : 1;
  localparam int IW = $clog2(MAX_DECIMALS + 2);

  logic                               h_valid;
  logic [MAX_DECIMALS:0][DIGIT_W-1:0] h_digs;
  fds_ctl_t                           h_ctl;
  logic [DEC_W-1:0]                   h_nd;
  logic [IW-1:0]                      h_idx;

  logic             found;
  logic [DEC_W-1:0] low_pos;
  logic [DEC_W-1:0] nd_in;

  logic [DEC_W-1:0]  idx_ext;
  logic [DEC_W-1:0]  pos;
  logic [PW-1:0]     pos_ix;
  logic [CHAR_W-1:0] cur_char;
  logic              cur_last;
  logic              out_load;

  // Count of fraction digits that remain after trailing zeros are trimmed.
  always_comb begin
    found   = 1'b0;
    low_pos = '0;
    for (int p = MAX_DECIMALS - 1; p >= 0; p--) begin
      if ((DEC_W'(p) < in_ctl.dec) && (in_digs[p] != '0)) begin
        found   = 1'b1;
        low_pos = DEC_W'(p);
      end
    end
    nd_in = found ? DEC_W'(in_ctl.dec - low_pos) : '0;
  end

  // Beat character: digit, point, then fraction digits; zero on error.
  always_comb begin
    idx_ext  = DEC_W'(h_idx);
    pos      = h_ctl.dec;
    cur_char = CHAR_NONE;
    cur_last = 1'b0;
    if (h_ctl.err) begin
      cur_last = 1'b1;
    end else if (idx_ext == '0) begin
      cur_char = CHAR_ZERO + CHAR_W'(h_digs[pos[PW-1:0]]);
    end else if (idx_ext == DEC_W'(1)) begin
      cur_char = CHAR_POINT;
      cur_last = (h_nd == '0);
    end else begin
      pos      = DEC_W'(h_ctl.dec - (idx_ext - DEC_W'(1)));
      cur_char = CHAR_ZERO + CHAR_W'(h_digs[pos[PW-1:0]]);
      cur_last = (idx_ext == DEC_W'(h_nd + DEC_W'(1)));
    end
    pos_ix = pos[PW-1:0];
  end

  // The output register takes a beat whenever it is empty or being drained.
  assign out_load = !m_tvalid || m_tready;
  assign in_ready = !h_valid || (out_load && cur_last);

  always_ff @(posedge clk) begin
    if (rst) begin
      h_valid <= 1'b0;
      h_idx   <= '0;
    end else if (in_ready) begin
      h_valid <= in_valid;
      h_idx   <= '0;
    end else if (out_load && h_valid) begin
      h_idx <= h_idx + IW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      h_digs <= in_digs;
      h_ctl  <= in_ctl;
      h_nd   <= nd_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= h_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load && h_valid) begin
      m_tdata <= (h_ctl.err) ? CHAR_NONE : (pos_ix == pos[PW-1:0] ? cur_char : CHAR_NONE);
      m_tlast <= cur_last;
      m_tuser <= h_ctl.err;
    end
  end

endmodule

@@ hdl/fixed_to_decimal_string.sv @@
// ---------------------------------------------------------------------------
// fixed_to_decimal_string: fixed point to rounded decimal ASCII converter
// Turns each 4.28 value into its rounded decimal string, one character
// per output beat.
// ---------------------------------------------------------------------------
// Usage:
//   Slave stream s_*: one 32-bit unsigned fixed-point value per beat.
//   Master stream m_*: one ASCII character per beat in tdata; tlast marks
//   the final character of a string; tuser flags an error beat, which is
//   a single beat with tdata zero and tlast high, sent when the integer
//   part exceeds nine before or after rounding.
//   decimals_wr_en / decimals_wr_data set the number of decimals (reset 2,
//   values above MAX_DECIMALS act as MAX_DECIMALS); write only when idle.
//   The first character of a value passes the multiply, the round, one
//   stage per digit, the serializer hold register and the output register.
//   Throughput: while m_tready is high the serializer sends one character
//   per cycle; a value takes 2 + kept fraction digits beats (2 to
//   MAX_DECIMALS + 2), one beat for an error; the pipeline accepts a beat
//   every cycle while the serializer keeps up.
//   Reset clears every valid flag and sets decimals to 2. When m_tready
//   is low, the output holds, the pipeline fills, and then s_tready drops.
// ---------------------------------------------------------------------------
module fixed_to_decimal_string #(
  parameter int MAX_DECIMALS = fds_pkg::DEF_MAX_DECIMALS,
  parameter int FRAC_BITS    = fds_pkg::DEF_FRAC_BITS
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        decimals_wr_en,
  input  logic [fds_pkg::DEC_W-1:0]   decimals_wr_data,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [fds_pkg::VALUE_W-1:0] s_tdata,   // [31:0] value
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [fds_pkg::CHAR_W-1:0]  m_tdata,   // [7:0] character
  output logic                        m_tlast,
  output logic                        m_tuser    // [0] overflow
);
  import fds_pkg::*;

  localparam int RW = fds_nbits(POW10[MAX_DECIMALS + 1]);
  localparam int NS = MAX_DECIMALS + 2;

  logic [DEC_W-1:0] decimals;

  logic                               ch_valid [NS];
  logic                               ch_ready [NS];
  logic [RW-1:0]                      ch_rem   [NS];
  logic [MAX_DECIMALS:0][DIGIT_W-1:0] ch_digs  [NS];
  fds_ctl_t                           ch_ctl   [NS];

  // Decimals register.
  always_ff @(posedge clk) begin
    if (rst) begin
      decimals <= RESET_DECIMALS;
    end else if (decimals_wr_en) begin
      decimals <= decimals_wr_data;
    end
  end

  // Scale and round.
  fds_front #(
    .MAX_DECIMALS(MAX_DECIMALS),
    .FRAC_BITS   (FRAC_BITS),
    .RW          (RW)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .in_value (s_tdata),
    .dec_cfg  (decimals),
    .out_valid(ch_valid[0]),
    .out_ready(ch_ready[0]),
    .out_rem  (ch_rem[0]),
    .out_ctl  (ch_ctl[0])
  );

  assign ch_digs[0] = '0;

  // One stage per decimal digit, most significant position first.
  for (genvar j = 0; j < NS - 1; j++) begin : g_digit
    fds_digit #(
      .MAX_DECIMALS(MAX_DECIMALS),
      .RW          (RW),
      .P           (MAX_DECIMALS - j)
    ) u_digit (
      .clk      (clk),
      .rst      (rst),
      .in_valid (ch_valid[j]),
      .in_ready (ch_ready[j]),
      .in_rem   (ch_rem[j]),
      .in_digs  (ch_digs[j]),
      .in_ctl   (ch_ctl[j]),
      .out_valid(ch_valid[j+1]),
      .out_ready(ch_ready[j+1]),
      .out_rem  (ch_rem[j+1]),
      .out_digs (ch_digs[j+1]),
      .out_ctl  (ch_ctl[j+1])
    );
  end

  // Trim and send the characters.
  fds_serial #(
    .MAX_DECIMALS(MAX_DECIMALS)
  ) u_serial (
    .clk     (clk),
    .rst     (rst),
    .in_valid(ch_valid[NS-1]),
    .in_ready(ch_ready[NS-1]),
    .in_digs (ch_digs[NS-1]),
    .in_ctl  (ch_ctl[NS-1]),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tlast (m_tlast),
    .m_tuser (m_tuser)
  );

`ifndef ASSERT_OFF
  // A value in range is fully consumed by the digit stages.
  a_rem_zero: assert property (@(posedge clk) disable iff (rst)
    (ch_valid[NS-1] && !ch_ctl[NS-1].err) |-> (ch_rem[NS-1] == '0))
    else $error("digit chain left a nonzero remainder");

  // An error beat is alone: zero character and end of string.
  a_err_beat: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser) |-> (m_tlast && (m_tdata == CHAR_NONE)))
    else $error("error beat is not a single zero character");

  // No error beat appears in the middle of a string.
  a_err_mid: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tready && !m_tlast) |=> !(m_tvalid && m_tuser))
    else $error("error beat inside a string");
`endif

endmodule

@@ tb/fds_checker.sv @@
// ---------------------------------------------------------------------------
// fds_checker: scoreboard for the decimal string converter
// Watches the decimals register writes and both streams. For each accepted
// input beat it works out the rounded decimal string the converter must
// emit and compares every output beat against the oldest pending character.
// ---------------------------------------------------------------------------
module fds_checker (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        decimals_wr_en,
  input  logic [fds_pkg::DEC_W-1:0]   decimals_wr_data,
  input  logic                        s_tvalid,
  input  logic                        s_tready,
  input  logic [fds_pkg::VALUE_W-1:0] s_tdata,   // [31:0] value
  input  logic                        m_tvalid,
  input  logic                        m_tready,
  input  logic [fds_pkg::CHAR_W-1:0]  m_tdata,   // [7:0] character
  input  logic                        m_tlast,
  input  logic                        m_tuser,   // [0] overflow
  output int                          fail_count,
  output int                          chars_pending
);
  timeunit 1ns;
  timeprecision 1ps;

  import fds_pkg::*;

  localparam int FRAC_BITS = DEF_FRAC_BITS;
  localparam int MAX_DEC   = DEF_MAX_DECIMALS;

  // One character of a string as it should appear on the output stream.
  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              last;
    logic              ovf;
  } char_beat_t;

  char_beat_t       expected_chars [$];
  logic [DEC_W-1:0] decimals;

  // Append one beat to the tail of the expected characters.
  task automatic queue_char(input logic [CHAR_W-1:0] ch, input logic last, input logic ovf);
    char_beat_t beat;
    beat = '{ch, last, ovf};
    expected_chars = {expected_chars, beat};
  endtask

  // Round the value half away from zero and queue its characters.
  task automatic predict_string(input logic [VALUE_W-1:0] value);
    int              places;
    int              kept;
    longint unsigned scale;
    longint unsigned rounded;
    longint unsigned ipart;
    longint unsigned frac;
    logic [3:0]      digit [MAX_DEC];
    places = (decimals > MAX_DEC) ? MAX_DEC : int'(decimals);
    scale = 1;
    for (int i = 0; i < places; i++) scale = scale * 10;
    // Integer part out of range before rounding.
    if ((value >> FRAC_BITS) > 9) begin
      queue_char(CHAR_NONE, 1'b1, 1'b1);
      return;
    end
    rounded = (longint'(value) * scale + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
    ipart = rounded / scale;
    frac = rounded % scale;
    // Rounding carried the integer part past nine.
    if (ipart > 9) begin
      queue_char(CHAR_NONE, 1'b1, 1'b1);
      return;
    end
    for (int i = places - 1; i >= 0; i--) begin
      digit[i] = 4'(frac % 10);
      frac = frac / 10;
    end
    // Trailing zeros are dropped, but the point always stays.
    kept = places;
    while (kept > 0 && digit[kept-1] == 4'd0) kept--;
    queue_char(CHAR_ZERO + 8'(ipart), 1'b0, 1'b0);
    queue_char(CHAR_POINT, kept == 0, 1'b0);
    for (int i = 0; i < kept; i++)
      queue_char(CHAR_ZERO + 8'(digit[i]), i + 1 == kept, 1'b0);
  endtask

  // Track the register, predict on input beats, and check output beats.
  always @(posedge clk) begin
    char_beat_t want;
    char_beat_t got;
    if (rst) begin
      expected_chars.delete();
      decimals <= RESET_DECIMALS;
      chars_pending <= 0;
    end else begin
      if (decimals_wr_en) decimals <= decimals_wr_data;
      if (m_tvalid && m_tready) begin
        got = '{m_tdata, m_tlast, m_tuser};
        if (expected_chars.size() == 0) begin
          $display("%0t: unexpected beat: char %h last %b ovf %b", $time,
                   got.ch, got.last, got.ovf);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_chars.pop_front();
          if (got.ch !== want.ch || got.last !== want.last || got.ovf !== want.ovf) begin
            $display("%0t: mismatch: expected char %h last %b ovf %b, got char %h last %b ovf %b",
                     $time, want.ch, want.last, want.ovf, got.ch, got.last, got.ovf);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (s_tvalid && s_tready) predict_string(s_tdata);
      chars_pending <= expected_chars.size();
    end
  end

endmodule

@@ tb/tb.sv @@
// ---------------------------------------------------------------------------
// tb: testbench of the decimal string converter
// Drives directed corner values and then random values through several
// decimals settings and flow-control patterns, and lets the checker decide
// whether every emitted character is right.
// ---------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import fds_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASE_BEATS = 36;
  localparam int SETTLE      = DEF_MAX_DECIMALS + 8;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               decimals_wr_en = 1'b0;
  logic [DEC_W-1:0]   decimals_wr_data = '0;
  logic               s_tvalid = 1'b0;
  logic               s_tready;
  logic [VALUE_W-1:0] s_tdata = '0;   // [31:0] value
  logic               m_tvalid;
  logic               m_tready = 1'b0;
  logic [CHAR_W-1:0]  m_tdata;        // [7:0] character
  logic               m_tlast;
  logic               m_tuser;        // [0] overflow

  int fail_count;
  int chars_pending;
  int cycle_count = 0;
  int send_idle = 0;
  int recv_stall = 0;

  logic [DEC_W-1:0] decimals_plan [8] = '{4'd2, 4'd0, 4'd8, 4'd15, 4'd1, 4'd5, 4'd9, 4'd3};

  fixed_to_decimal_string uut (
    .clk              (clk),
    .rst              (rst),
    .decimals_wr_en   (decimals_wr_en),
    .decimals_wr_data (decimals_wr_data),
    .s_tvalid         (s_tvalid),
    .s_tready         (s_tready),
    .s_tdata          (s_tdata),
    .m_tvalid         (m_tvalid),
    .m_tready         (m_tready),
    .m_tdata          (m_tdata),
    .m_tlast          (m_tlast),
    .m_tuser          (m_tuser)
  );

  fds_checker u_checker (
    .clk              (clk),
    .rst              (rst),
    .decimals_wr_en   (decimals_wr_en),
    .decimals_wr_data (decimals_wr_data),
    .s_tvalid         (s_tvalid),
    .s_tready         (s_tready),
    .s_tdata          (s_tdata),
    .m_tvalid         (m_tvalid),
    .m_tready         (m_tready),
    .m_tdata          (m_tdata),
    .m_tlast          (m_tlast),
    .m_tuser          (m_tuser),
    .fail_count       (fail_count),
    .chars_pending    (chars_pending)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // The receiver stalls at random with the current phase's odds.
  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= recv_stall);
  end

  // Watchdog against a hung handshake.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Offer one value, idling first at the phase's odds, and wait for its beat.
  task automatic send_value(input logic [VALUE_W-1:0] value);
    while ($urandom_range(99) < send_idle) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= value;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  // Wait until every predicted character has been seen.
  task automatic drain();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (chars_pending != 0);
  endtask

  // Change the decimals register once the converter has gone quiet.
  task automatic set_decimals(input logic [DEC_W-1:0] places);
    drain();
    repeat (SETTLE) @(posedge clk);
    decimals_wr_en <= 1'b1;
    decimals_wr_data <= places;
    @(posedge clk);
    decimals_wr_en <= 1'b0;
  endtask

  // Mostly in-range values, with carries near ten, out-of-range values,
  // short fractions that leave trailing zeros, and raw 32-bit noise.
  function automatic logic [VALUE_W-1:0] random_value();
    case ($urandom_range(9))
      6: return $urandom_range(32'hFFFF_FFFF, 32'hA000_0000);
      7: return 32'h9F00_0000 | $urandom_range(32'h00FF_FFFF, 0);
      8: return (VALUE_W'($urandom_range(9)) << 28) | (VALUE_W'($urandom_range(15)) << 24);
      9: return $urandom;
      default: return $urandom_range(32'h9FFF_FFFF, 0);
    endcase
  endfunction

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed values at the reset setting of two places.
    send_value(32'h0000_0000);
    send_value(32'h9FFF_FFFF);   // rounds up past nine
    send_value(32'hA000_0000);   // integer part out of range
    send_value(32'hFFFF_FFFF);
    send_value(32'h3000_0000);   // all fraction digits trimmed
    send_value(32'h0200_0000);   // exactly half at the last place
    send_value(32'h01FF_FFFF);
    send_value(32'h5FFF_FFFF);   // carry into the integer digit
    send_value(32'h1CCC_CCCD);
    // No fraction digits at all.
    set_decimals(4'd0);
    send_value(32'h0800_0000);
    send_value(32'h07FF_FFFF);
    send_value(32'h9800_0000);
    send_value(32'h9400_0000);
    send_value(32'h5555_5555);
    // Widest setting.
    set_decimals(4'd8);
    send_value(32'h0000_0001);
    send_value(32'h0000_0002);
    send_value(32'h9FFF_FFFF);
    send_value(32'h9FFF_FFF0);
    send_value(32'h1234_5678);
    // Register value beyond the limit acts as the widest setting.
    set_decimals(4'd15);
    send_value(32'h9FFF_FFF0);
    send_value(32'h2AAA_AAAA);
    send_value(32'h0000_000B);

    // Random phases over settings and flow-control patterns.
    for (int ph = 0; ph < 8; ph++) begin
      set_decimals(ph == 7 ? 4'($urandom_range(15)) : decimals_plan[ph]);
      case (ph % 4)
        0: begin send_idle = 0;  recv_stall = 0;  end
        1: begin send_idle = 81; recv_stall = 0;  end
        2: begin send_idle = 0;  recv_stall = 81; end
        default: begin send_idle = 31; recv_stall = 31; end
      endcase
      repeat (PHASE_BEATS) send_value(random_value());
    end

    drain();
    repeat (SETTLE) @(posedge clk);
    if (fail_count == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule
